// ===== sv/pec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pair elastic collision pipeline.
// No dependencies; used by the channel interfaces, the top level and the checker.
package pec_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int WEIGHT_BITS = 32;
   localparam int SQRT_STEPS  = 32;
   localparam int NDIV_STEPS  = 16;
   localparam int POST_STAGES = 7;
   localparam int LATENCY     = 2 + (SQRT_STEPS + 1) + (NDIV_STEPS + 1) + POST_STAGES + 1;

   typedef struct packed {
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic signed [31:0] a_vel_x;
      logic signed [31:0] a_vel_y;
      logic        [30:0] a_radius;
      logic        [30:0] a_mass;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic signed [31:0] b_vel_x;
      logic signed [31:0] b_vel_y;
      logic        [30:0] b_radius;
      logic        [30:0] b_mass;
   } req_type;

   typedef struct packed {
      logic               touching;
      logic signed [31:0] a_new_pos_x;
      logic signed [31:0] a_new_pos_y;
      logic signed [31:0] a_new_vel_x;
      logic signed [31:0] a_new_vel_y;
      logic signed [31:0] b_new_pos_x;
      logic signed [31:0] b_new_pos_y;
      logic signed [31:0] b_new_vel_x;
      logic signed [31:0] b_new_vel_y;
   } rsp_type;

endpackage

// ===== sv/pec_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for disc pair items and collision results.
// Depends on pec_pkg for the payload types.
interface pec_req_if;
   logic              valid;
   logic              ready;
   pec_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface pec_rsp_if;
   logic              valid;
   logic              ready;
   pec_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pair_elastic_collision_top.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle; input ready follows result ready while a result item waits.
// Most of the latency comes from the 32 square root stages and the 16 normal divide stages.
// A stalled result holds every stage; nothing is lost or repeated.
// Reset (synchronous) clears the stage valid bits only; payload registers are not reset.
module pair_elastic_collision_top (
   input  logic       clock,
   input  logic       reset,
   pec_req_if.sink    req_ch,
   pec_rsp_if.source  rsp_ch
);

   localparam int LAT = pec_pkg::LATENCY;
   localparam int FB  = pec_pkg::FRAC_BITS;
   localparam int SQ  = pec_pkg::SQRT_STEPS;
   localparam int ND  = pec_pkg::NDIV_STEPS;

   localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (pec_pkg::WORD_BITS - 1)) - 40'sd1;
   localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

   typedef struct packed {
      logic signed [31:0] ax, ay, avx, avy, bx, by, bvx, bvy;
      logic               dx_neg, dy_neg;
      logic        [31:0] ux, uy, rs;
      logic               touch;
   } ctx_type;

   typedef struct packed {
      ctx_type     c;
      logic [30:0] am, bm;
      logic [31:0] tot;
   } s0_type;

   typedef struct packed {
      ctx_type     c;
      logic [63:0] sx2, sy2, rs2;
      logic [30:0] am, bm;
      logic [31:0] tot;
   } s1_type;

   typedef struct packed {
      ctx_type     c;
      logic [63:0] v, root;
      logic [32:0] rem_a, rem_b;
      logic [31:0] q_a, q_b, tot;
   } sr_type;

   typedef struct packed {
      ctx_type     c;
      logic [31:0] dlen, wa, wb;
      logic [32:0] rem_x, rem_y;
      logic [16:0] q_x, q_y;
   } dv_type;

   typedef struct packed {
      ctx_type            c;
      logic        [16:0] nxm, nym;
      logic        [31:0] wa, wb, ov;
      logic signed [32:0] dvx, dvy;
      logic signed [17:0] nxs, nys;
   } t0_type;

   typedef struct packed {
      ctx_type            c;
      logic        [16:0] nxm, nym;
      logic        [31:0] wa, wb;
      logic        [47:0] pa_hi, pa_lo, pb_hi, pb_lo;
      logic signed [50:0] vx_p, vy_p;
   } t1_type;

   typedef struct packed {
      ctx_type            c;
      logic        [16:0] nxm, nym;
      logic        [31:0] wa, wb, sa, sb;
      logic signed [51:0] vn;
   } t2_type;

   typedef struct packed {
      ctx_type     c;
      logic [16:0] nxm, nym;
      logic [31:0] wa, wb;
      logic [48:0] qax, qay, qbx, qby;
      logic        vneg;
      logic [36:0] x;
   } t3_type;

   typedef struct packed {
      ctx_type     c;
      logic [16:0] nxm, nym;
      logic        vneg;
      logic [52:0] xa_hi, xa_lo, xb_hi, xb_lo;
   } t4_type;

   typedef struct packed {
      ctx_type     c;
      logic [16:0] nxm, nym;
      logic        vneg;
      logic [36:0] da, db;
   } t5_type;

   typedef struct packed {
      ctx_type     c;
      logic        vneg;
      logic [53:0] rax, ray, rbx, rby;
   } t6_type;

   function automatic logic signed [31:0] sat_word(input logic signed [39:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[31:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[31:0];
      end
      return v[31:0];
   endfunction

   function automatic logic signed [39:0] nterm(input logic neg, input logic [37:0] p);
      logic signed [39:0] e;
      e = signed'({2'b00, p});
      return neg ? -e : e;
   endfunction

   function automatic logic signed [39:0] ext(input logic signed [31:0] v);
      return 40'(v);
   endfunction

   logic               en;
   logic               accept;
   logic [LAT-1:0]     vld_ff;

   s0_type  s0_ff, s0_in;
   s1_type  s1_ff, s1_in;
   sr_type  sr_ff [SQ+1];
   sr_type  sr0_in;
   dv_type  dv_ff [ND+1];
   dv_type  dv0_in;
   t0_type  t0_ff, t0_in;
   t1_type  t1_ff, t1_in;
   t2_type  t2_ff, t2_in;
   t3_type  t3_ff, t3_in;
   t4_type  t4_ff, t4_in;
   t5_type  t5_ff, t5_in;
   t6_type  t6_ff, t6_in;
   pec_pkg::rsp_type out_ff, out_in;

   assign en           = !vld_ff[LAT-1] || rsp_ch.ready;
   assign accept       = req_ch.valid && en;
   assign req_ch.ready = en;
   assign rsp_ch.valid = vld_ff[LAT-1];
   assign rsp_ch.data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // stage 0: differences, radius sum, mass clamp
   always_comb begin
      logic signed [32:0] dx, dy;
      logic        [30:0] am, bm;
      dx = 33'(req_ch.data.b_pos_x) - 33'(req_ch.data.a_pos_x);
      dy = 33'(req_ch.data.b_pos_y) - 33'(req_ch.data.a_pos_y);
      am = (req_ch.data.a_mass == '0) ? 31'd1 : req_ch.data.a_mass;
      bm = (req_ch.data.b_mass == '0) ? 31'd1 : req_ch.data.b_mass;
      s0_in.c.ax     = req_ch.data.a_pos_x;
      s0_in.c.ay     = req_ch.data.a_pos_y;
      s0_in.c.avx    = req_ch.data.a_vel_x;
      s0_in.c.avy    = req_ch.data.a_vel_y;
      s0_in.c.bx     = req_ch.data.b_pos_x;
      s0_in.c.by     = req_ch.data.b_pos_y;
      s0_in.c.bvx    = req_ch.data.b_vel_x;
      s0_in.c.bvy    = req_ch.data.b_vel_y;
      s0_in.c.dx_neg = dx[32];
      s0_in.c.dy_neg = dy[32];
      s0_in.c.ux     = dx[32] ? 32'(-dx) : dx[31:0];
      s0_in.c.uy     = dy[32] ? 32'(-dy) : dy[31:0];
      s0_in.c.rs     = {1'b0, req_ch.data.a_radius} + {1'b0, req_ch.data.b_radius};
      s0_in.c.touch  = 1'b0;
      s0_in.am       = am;
      s0_in.bm       = bm;
      s0_in.tot      = {1'b0, am} + {1'b0, bm};
   end

   // stage 1: squares
   always_comb begin
      s1_in.c   = s0_ff.c;
      s1_in.sx2 = 64'(s0_ff.c.ux) * 64'(s0_ff.c.ux);
      s1_in.sy2 = 64'(s0_ff.c.uy) * 64'(s0_ff.c.uy);
      s1_in.rs2 = 64'(s0_ff.c.rs) * 64'(s0_ff.c.rs);
      s1_in.am  = s0_ff.am;
      s1_in.bm  = s0_ff.bm;
      s1_in.tot = s0_ff.tot;
   end

   // stage 2: squared distance, contact test, root and weight divide setup
   always_comb begin
      logic [64:0] sum;
      sum             = {1'b0, s1_ff.sx2} + {1'b0, s1_ff.sy2};
      sr0_in.c        = s1_ff.c;
      sr0_in.c.touch  = !sum[64] && (sum[63:0] <= s1_ff.rs2);
      sr0_in.v        = sum[63:0];
      sr0_in.root     = '0;
      sr0_in.rem_a    = {2'b00, s1_ff.bm};
      sr0_in.rem_b    = {2'b00, s1_ff.am};
      sr0_in.q_a      = '0;
      sr0_in.q_b      = '0;
      sr0_in.tot      = s1_ff.tot;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff    <= s0_in;
         s1_ff    <= s1_in;
         sr_ff[0] <= sr0_in;
      end
   end

   // one root digit and one quotient bit of each mass weight per stage
   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
      sr_type sr_in;
      always_comb begin
         logic [63:0] tb;
         logic [32:0] r2a, r2b;
         sr_in = sr_ff[k];
         tb    = sr_ff[k].root + RBIT;
         if (sr_ff[k].v >= tb) begin
            sr_in.v    = sr_ff[k].v - tb;
            sr_in.root = (sr_ff[k].root >> 1) + RBIT;
         end else begin
            sr_in.root = sr_ff[k].root >> 1;
         end
         r2a = {sr_ff[k].rem_a[31:0], 1'b0};
         r2b = {sr_ff[k].rem_b[31:0], 1'b0};
         if (r2a >= {1'b0, sr_ff[k].tot}) begin
            sr_in.rem_a = r2a - {1'b0, sr_ff[k].tot};
            sr_in.q_a   = {sr_ff[k].q_a[30:0], 1'b1};
         end else begin
            sr_in.rem_a = r2a;
            sr_in.q_a   = {sr_ff[k].q_a[30:0], 1'b0};
         end
         if (r2b >= {1'b0, sr_ff[k].tot}) begin
            sr_in.rem_b = r2b - {1'b0, sr_ff[k].tot};
            sr_in.q_b   = {sr_ff[k].q_b[30:0], 1'b1};
         end else begin
            sr_in.rem_b = r2b;
            sr_in.q_b   = {sr_ff[k].q_b[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sr_ff[k+1] <= sr_in;
         end
      end
   end

   // normal divide setup: integer quotient bit
   always_comb begin
      logic [31:0] dlen;
      dlen        = sr_ff[SQ].root[31:0];
      dv0_in.c    = sr_ff[SQ].c;
      dv0_in.dlen = dlen;
      dv0_in.wa   = sr_ff[SQ].q_a;
      dv0_in.wb   = sr_ff[SQ].q_b;
      if (sr_ff[SQ].c.ux >= dlen) begin
         dv0_in.rem_x = {1'b0, sr_ff[SQ].c.ux - dlen};
         dv0_in.q_x   = 17'd1;
      end else begin
         dv0_in.rem_x = {1'b0, sr_ff[SQ].c.ux};
         dv0_in.q_x   = 17'd0;
      end
      if (sr_ff[SQ].c.uy >= dlen) begin
         dv0_in.rem_y = {1'b0, sr_ff[SQ].c.uy - dlen};
         dv0_in.q_y   = 17'd1;
      end else begin
         dv0_in.rem_y = {1'b0, sr_ff[SQ].c.uy};
         dv0_in.q_y   = 17'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= dv0_in;
      end
   end

   // one fraction bit of each normal component per stage
   for (genvar j = 0; j < ND; j++) begin : g_ndiv
      dv_type dv_in;
      always_comb begin
         logic [32:0] r2x, r2y;
         dv_in = dv_ff[j];
         r2x   = {dv_ff[j].rem_x[31:0], 1'b0};
         r2y   = {dv_ff[j].rem_y[31:0], 1'b0};
         if (r2x >= {1'b0, dv_ff[j].dlen}) begin
            dv_in.rem_x = r2x - {1'b0, dv_ff[j].dlen};
            dv_in.q_x   = {dv_ff[j].q_x[15:0], 1'b1};
         end else begin
            dv_in.rem_x = r2x;
            dv_in.q_x   = {dv_ff[j].q_x[15:0], 1'b0};
         end
         if (r2y >= {1'b0, dv_ff[j].dlen}) begin
            dv_in.rem_y = r2y - {1'b0, dv_ff[j].dlen};
            dv_in.q_y   = {dv_ff[j].q_y[15:0], 1'b1};
         end else begin
            dv_in.rem_y = r2y;
            dv_in.q_y   = {dv_ff[j].q_y[15:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j+1] <= dv_in;
         end
      end
   end

   // post 0: normal with coincident fallback, overlap, relative velocity
   always_comb begin
      logic [16:0] nxm, nym;
      nxm = (dv_ff[ND].dlen == '0) ? (17'd1 << FB) : dv_ff[ND].q_x;
      nym = (dv_ff[ND].dlen == '0) ? 17'd0 : dv_ff[ND].q_y;
      t0_in.c   = dv_ff[ND].c;
      t0_in.nxm = nxm;
      t0_in.nym = nym;
      t0_in.wa  = dv_ff[ND].wa;
      t0_in.wb  = dv_ff[ND].wb;
      t0_in.ov  = dv_ff[ND].c.rs - dv_ff[ND].dlen;
      t0_in.dvx = 33'(dv_ff[ND].c.bvx) - 33'(dv_ff[ND].c.avx);
      t0_in.dvy = 33'(dv_ff[ND].c.bvy) - 33'(dv_ff[ND].c.avy);
      t0_in.nxs = dv_ff[ND].c.dx_neg ? -signed'({1'b0, nxm}) : signed'({1'b0, nxm});
      t0_in.nys = dv_ff[ND].c.dy_neg ? -signed'({1'b0, nym}) : signed'({1'b0, nym});
   end

   // post 1: overlap weight partials, normal velocity products
   always_comb begin
      t1_in.c     = t0_ff.c;
      t1_in.nxm   = t0_ff.nxm;
      t1_in.nym   = t0_ff.nym;
      t1_in.wa    = t0_ff.wa;
      t1_in.wb    = t0_ff.wb;
      t1_in.pa_hi = 48'(t0_ff.ov) * 48'(t0_ff.wa[31:16]);
      t1_in.pa_lo = 48'(t0_ff.ov) * 48'(t0_ff.wa[15:0]);
      t1_in.pb_hi = 48'(t0_ff.ov) * 48'(t0_ff.wb[31:16]);
      t1_in.pb_lo = 48'(t0_ff.ov) * 48'(t0_ff.wb[15:0]);
      t1_in.vx_p  = 51'(t0_ff.dvx) * 51'(t0_ff.nxs);
      t1_in.vy_p  = 51'(t0_ff.dvy) * 51'(t0_ff.nys);
   end

   // post 2: position shifts, normal velocity
   always_comb begin
      logic [48:0] sa, sb;
      sa        = {1'b0, t1_ff.pa_hi} + 49'(t1_ff.pa_lo >> 16);
      sb        = {1'b0, t1_ff.pb_hi} + 49'(t1_ff.pb_lo >> 16);
      t2_in.c   = t1_ff.c;
      t2_in.nxm = t1_ff.nxm;
      t2_in.nym = t1_ff.nym;
      t2_in.wa  = t1_ff.wa;
      t2_in.wb  = t1_ff.wb;
      t2_in.sa  = sa[47:16];
      t2_in.sb  = sb[47:16];
      t2_in.vn  = 52'(t1_ff.vx_p) + 52'(t1_ff.vy_p);
   end

   // post 3: position terms along the normal, impulse magnitude
   always_comb begin
      logic [51:0] mag;
      mag        = t2_ff.vn[51] ? 52'(-t2_ff.vn) : t2_ff.vn;
      t3_in.c    = t2_ff.c;
      t3_in.nxm  = t2_ff.nxm;
      t3_in.nym  = t2_ff.nym;
      t3_in.wa   = t2_ff.wa;
      t3_in.wb   = t2_ff.wb;
      t3_in.qax  = 49'(t2_ff.nxm) * 49'(t2_ff.sa);
      t3_in.qay  = 49'(t2_ff.nym) * 49'(t2_ff.sa);
      t3_in.qbx  = 49'(t2_ff.nxm) * 49'(t2_ff.sb);
      t3_in.qby  = 49'(t2_ff.nym) * 49'(t2_ff.sb);
      t3_in.vneg = t2_ff.vn[51];
      t3_in.x    = mag[51:15];
   end

   // post 4: corrected positions, impulse weight partials
   always_comb begin
      t4_in.c = t3_ff.c;
      if (t3_ff.c.touch) begin
         t4_in.c.ax = sat_word(ext(t3_ff.c.ax)
                      - nterm(t3_ff.c.dx_neg, 38'(t3_ff.qax[48:FB])));
         t4_in.c.ay = sat_word(ext(t3_ff.c.ay)
                      - nterm(t3_ff.c.dy_neg, 38'(t3_ff.qay[48:FB])));
         t4_in.c.bx = sat_word(ext(t3_ff.c.bx)
                      + nterm(t3_ff.c.dx_neg, 38'(t3_ff.qbx[48:FB])));
         t4_in.c.by = sat_word(ext(t3_ff.c.by)
                      + nterm(t3_ff.c.dy_neg, 38'(t3_ff.qby[48:FB])));
      end
      t4_in.nxm   = t3_ff.nxm;
      t4_in.nym   = t3_ff.nym;
      t4_in.vneg  = t3_ff.vneg;
      t4_in.xa_hi = 53'(t3_ff.x) * 53'(t3_ff.wa[31:16]);
      t4_in.xa_lo = 53'(t3_ff.x) * 53'(t3_ff.wa[15:0]);
      t4_in.xb_hi = 53'(t3_ff.x) * 53'(t3_ff.wb[31:16]);
      t4_in.xb_lo = 53'(t3_ff.x) * 53'(t3_ff.wb[15:0]);
   end

   // post 5: velocity changes
   always_comb begin
      logic [53:0] da, db;
      da         = {1'b0, t4_ff.xa_hi} + 54'(t4_ff.xa_lo >> 16);
      db         = {1'b0, t4_ff.xb_hi} + 54'(t4_ff.xb_lo >> 16);
      t5_in.c    = t4_ff.c;
      t5_in.nxm  = t4_ff.nxm;
      t5_in.nym  = t4_ff.nym;
      t5_in.vneg = t4_ff.vneg;
      t5_in.da   = da[52:16];
      t5_in.db   = db[52:16];
   end

   // post 6: velocity terms along the normal
   always_comb begin
      t6_in.c    = t5_ff.c;
      t6_in.vneg = t5_ff.vneg;
      t6_in.rax  = 54'(t5_ff.nxm) * 54'(t5_ff.da);
      t6_in.ray  = 54'(t5_ff.nym) * 54'(t5_ff.da);
      t6_in.rbx  = 54'(t5_ff.nxm) * 54'(t5_ff.db);
      t6_in.rby  = 54'(t5_ff.nym) * 54'(t5_ff.db);
   end

   // result: apply impulse only to approaching pairs in contact
   always_comb begin
      out_in.touching    = t6_ff.c.touch;
      out_in.a_new_pos_x = t6_ff.c.ax;
      out_in.a_new_pos_y = t6_ff.c.ay;
      out_in.b_new_pos_x = t6_ff.c.bx;
      out_in.b_new_pos_y = t6_ff.c.by;
      out_in.a_new_vel_x = t6_ff.c.avx;
      out_in.a_new_vel_y = t6_ff.c.avy;
      out_in.b_new_vel_x = t6_ff.c.bvx;
      out_in.b_new_vel_y = t6_ff.c.bvy;
      if (t6_ff.c.touch && t6_ff.vneg) begin
         out_in.a_new_vel_x = sat_word(ext(t6_ff.c.avx)
                              - nterm(t6_ff.c.dx_neg, t6_ff.rax[53:FB]));
         out_in.a_new_vel_y = sat_word(ext(t6_ff.c.avy)
                              - nterm(t6_ff.c.dy_neg, t6_ff.ray[53:FB]));
         out_in.b_new_vel_x = sat_word(ext(t6_ff.c.bvx)
                              + nterm(t6_ff.c.dx_neg, t6_ff.rbx[53:FB]));
         out_in.b_new_vel_y = sat_word(ext(t6_ff.c.bvy)
                              + nterm(t6_ff.c.dy_neg, t6_ff.rby[53:FB]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_ff  <= t0_in;
         t1_ff  <= t1_in;
         t2_ff  <= t2_in;
         t3_ff  <= t3_in;
         t4_ff  <= t4_in;
         t5_ff  <= t5_in;
         t6_ff  <= t6_in;
         out_ff <= out_in;
      end
   end

endmodule

// ===== sv/pec_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for pair_elastic_collision_top and the bind that attaches them.
// Depends on pec_pkg and the top level.
module pec_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pec_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while pipeline stalled");

   a_free_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input held off with empty output");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_req_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_ready))
      else $error("input ready unknown while an item is offered");

endmodule

bind pair_elastic_collision_top pec_checker u_pec_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

// ===== test/pair_elastic_collision_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the disc pair collision pipeline: random and directed
// pairs go in over the request channel, and each result is checked against a
// local fixed-point model. Depends on pec_pkg, pec_if.sv and the top level.
module pair_elastic_collision_top_tb;

   localparam logic [63:0] ONE_Q = 64'd1 << pec_pkg::FRAC_BITS;
   localparam int N_DIRECTED = 12;
   localparam int N_ITEMS    = 552;
   localparam int REQ_BITS   = $bits(pec_pkg::req_type);

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count = 0;
   int   touch_count = 0;
   int   sent_count = 0;
   int   checked_count = 0;
   bit   rsp_hold = 1'b0;
   bit   req_taken = 1'b0;

   pec_pkg::req_type pending_pairs[$];
   pec_pkg::rsp_type expected_results[$];

   pec_req_if req_ch ();
   pec_rsp_if rsp_ch ();

   pair_elastic_collision_top dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] scale_by_weight(input logic [63:0] x, input logic [63:0] w);
      logic [127:0] p;
      p = 128'(x) * 128'(w);
      return p[95:32];
   endfunction

   function automatic logic signed [63:0] project(input logic signed [63:0] n,
                                                  input logic [63:0] m);
      logic [63:0] p;
      p = (mag64(n) * m) >> pec_pkg::FRAC_BITS;
      return n < 0 ? -$signed(p) : $signed(p);
   endfunction

   function automatic pec_pkg::rsp_type resolve_contact(input pec_pkg::req_type q);
      pec_pkg::rsp_type r;
      logic signed [63:0] ax, ay, avx, avy, bx, by, bvx, bvy, dx, dy, nx, ny;
      logic [64:0] dist_sq;
      logic [63:0] ux, uy, rsum, dlen, am, bm, tot, wa, wb, ov, sa, sb, x, da, db;
      logic signed [127:0] vn;
      logic touch;
      ax = q.a_pos_x; ay = q.a_pos_y; avx = q.a_vel_x; avy = q.a_vel_y;
      bx = q.b_pos_x; by = q.b_pos_y; bvx = q.b_vel_x; bvy = q.b_vel_y;
      dx = bx - ax; dy = by - ay;
      ux = mag64(dx); uy = mag64(dy);
      dist_sq = 65'(ux * ux) + 65'(uy * uy);
      rsum = 64'(q.a_radius) + 64'(q.b_radius);
      touch = !dist_sq[64] && dist_sq[63:0] <= rsum * rsum;
      if (touch) begin
         dlen = root_floor(dist_sq[63:0]);
         if (dlen == 0) begin
            nx = ONE_Q; ny = 0;
         end else begin
            nx = (ux << pec_pkg::FRAC_BITS) / dlen;
            ny = (uy << pec_pkg::FRAC_BITS) / dlen;
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
         end
         am = q.a_mass == 0 ? 64'd1 : 64'(q.a_mass);
         bm = q.b_mass == 0 ? 64'd1 : 64'(q.b_mass);
         tot = am + bm;
         wa = (bm << pec_pkg::WEIGHT_BITS) / tot;
         wb = (am << pec_pkg::WEIGHT_BITS) / tot;
         ov = rsum - dlen;
         sa = scale_by_weight(ov, wa);
         sb = scale_by_weight(ov, wb);
         ax = sat32(ax - project(nx, sa));
         ay = sat32(ay - project(ny, sa));
         bx = sat32(bx + project(nx, sb));
         by = sat32(by + project(ny, sb));
         vn = 128'(bvx - avx) * 128'(nx) + 128'(bvy - avy) * 128'(ny);
         if (vn < 0) begin
            x = 64'((128'd0 - 128'(vn)) * 2 >> pec_pkg::FRAC_BITS);
            da = scale_by_weight(x, wa);
            db = scale_by_weight(x, wb);
            avx = sat32(avx - project(nx, da));
            avy = sat32(avy - project(ny, da));
            bvx = sat32(bvx + project(nx, db));
            bvy = sat32(bvy + project(ny, db));
         end
      end
      r.touching = touch;
      r.a_new_pos_x = ax[31:0]; r.a_new_pos_y = ay[31:0];
      r.a_new_vel_x = avx[31:0]; r.a_new_vel_y = avy[31:0];
      r.b_new_pos_x = bx[31:0]; r.b_new_pos_y = by[31:0];
      r.b_new_vel_x = bvx[31:0]; r.b_new_vel_y = bvy[31:0];
      return r;
   endfunction

   function automatic int gap_length();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(0, 131072)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   // Random pair, mostly near contact so the collision path gets exercised.
   function automatic pec_pkg::req_type random_pair();
      pec_pkg::req_type q;
      int span;
      span = 1 << $urandom_range(10, 26);
      q.a_pos_x = ($urandom_range(0, 9) == 0) ? rand_word() : 32'($urandom % (1 << 28)) - (1 << 27);
      q.a_pos_y = ($urandom_range(0, 9) == 0) ? rand_word() : 32'($urandom % (1 << 28)) - (1 << 27);
      q.b_pos_x = q.a_pos_x + 32'(int'($urandom_range(0, 2 * span)) - span);
      q.b_pos_y = q.a_pos_y + 32'(int'($urandom_range(0, 2 * span)) - span);
      q.a_radius = 31'($urandom_range(0, span));
      q.b_radius = 31'($urandom_range(0, span));
      q.a_vel_x = rand_word(); q.a_vel_y = rand_word();
      q.b_vel_x = rand_word(); q.b_vel_y = rand_word();
      q.a_mass = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
      q.b_mass = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 20));
      if ($urandom_range(0, 5) == 0) begin
         q = pec_pkg::req_type'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, $urandom, $urandom}));
      end
      return q;
   endfunction

   function automatic pec_pkg::req_type rest_pair(input logic [31:0] bx,
                                                  input logic [31:0] by,
                                                  input logic [30:0] r,
                                                  input logic [30:0] m);
      pec_pkg::req_type q;
      q = '0;
      q.a_radius = r; q.b_radius = r; q.a_mass = m; q.b_mass = m;
      q.b_pos_x = bx; q.b_pos_y = by;
      return q;
   endfunction

   initial begin
      pec_pkg::req_type q;
      pending_pairs.push_back(rest_pair(32'h0003_0000, 0, 31'h1_0000, 31'h1_0000));
      q = rest_pair(0, 0, 31'h1_0000, 31'h1_0000);
      q.a_vel_x = 32'h0001_0000;
      pending_pairs.push_back(q);
      q = rest_pair(32'h0002_0000, 0, 31'h1_0000, 31'h1_0000);
      pending_pairs.push_back(q);
      q = rest_pair(32'hffff_0000, 32'h0000_8000, 31'h1_0000, 0);
      q.a_vel_x = 32'h7fffffff; q.b_vel_x = 32'h80000000;
      q.a_vel_y = 32'h80000000; q.b_vel_y = 32'h7fffffff;
      pending_pairs.push_back(q);
      q = rest_pair(32'h0000_8000, 32'hffff_8000, 31'h7fffffff, 31'h7fffffff);
      q.a_pos_x = 32'h7fff_0000; q.b_pos_x = 32'h7fff_8000;
      q.a_vel_x = 32'h0010_0000; q.b_vel_x = 32'hfff0_0000;
      pending_pairs.push_back(q);
      q = rest_pair(32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff);
      q.a_pos_x = 32'h7fffffff; q.a_pos_y = 32'h7fffffff;
      pending_pairs.push_back(q);
      q = rest_pair(32'h80000000, 0, 31'h7fffffff, 1);
      q.a_pos_x = 32'h7fffffff;
      q.b_mass = 31'h7fffffff;
      pending_pairs.push_back(q);
      q = rest_pair(32'h0001_0000, 32'h0001_0000, 31'h0000_b505, 31'h1_0000);
      q.b_vel_x = 32'hffff_0000; q.b_vel_y = 32'hffff_0000;
      pending_pairs.push_back(q);
      q = rest_pair(32'h0001_0000, 0, 31'h0000_8000, 31'h1_0000);
      q.b_vel_x = 32'h0001_0000;
      pending_pairs.push_back(q);
      pending_pairs.push_back(rest_pair(0, 0, 0, 0));
      q = '1;
      pending_pairs.push_back(q);
      q = '0;
      pending_pairs.push_back(q);
      for (int i = 0; i < N_ITEMS - N_DIRECTED; i++) pending_pairs.push_back(random_pair());
   end

   // Request driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (req_gap > 0) begin
            req_ch.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_pairs.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_pairs.pop_front();
            req_gap <= gap_length();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_results.push_back(resolve_contact(req_ch.data));
         sent_count <= sent_count + 1;
      end
   end

   // Result ready with random stalls, plus one long hold-off
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_gap <= gap_length();
      end
   end

   initial begin
      int held;
      wait (sent_count >= 150);
      rsp_hold = 1'b1;
      held = 0;
      while (held < 300) begin
         @(posedge clock);
         held++;
      end
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      pec_pkg::rsp_type want;
      pec_pkg::rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (expected_results.size() == 0) begin
            $error("unexpected result item");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            checked_count++;
            if (want.touching) touch_count++;
            if (got.touching !== want.touching) begin
               $error("touching exp %0d got %0d", want.touching, got.touching); fail_count++;
            end
            if (got.a_new_pos_x !== want.a_new_pos_x) begin
               $error("a_new_pos_x exp %h got %h", want.a_new_pos_x, got.a_new_pos_x); fail_count++;
            end
            if (got.a_new_pos_y !== want.a_new_pos_y) begin
               $error("a_new_pos_y exp %h got %h", want.a_new_pos_y, got.a_new_pos_y); fail_count++;
            end
            if (got.a_new_vel_x !== want.a_new_vel_x) begin
               $error("a_new_vel_x exp %h got %h", want.a_new_vel_x, got.a_new_vel_x); fail_count++;
            end
            if (got.a_new_vel_y !== want.a_new_vel_y) begin
               $error("a_new_vel_y exp %h got %h", want.a_new_vel_y, got.a_new_vel_y); fail_count++;
            end
            if (got.b_new_pos_x !== want.b_new_pos_x) begin
               $error("b_new_pos_x exp %h got %h", want.b_new_pos_x, got.b_new_pos_x); fail_count++;
            end
            if (got.b_new_pos_y !== want.b_new_pos_y) begin
               $error("b_new_pos_y exp %h got %h", want.b_new_pos_y, got.b_new_pos_y); fail_count++;
            end
            if (got.b_new_vel_x !== want.b_new_vel_x) begin
               $error("b_new_vel_x exp %h got %h", want.b_new_vel_x, got.b_new_vel_x); fail_count++;
            end
            if (got.b_new_vel_y !== want.b_new_vel_y) begin
               $error("b_new_vel_y exp %h got %h", want.b_new_vel_y, got.b_new_vel_y); fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (checked_count == N_ITEMS);
      repeat (pec_pkg::LATENCY + 20) @(posedge clock);
      $display("checked %0d pairs, %0d in contact, including a long result stall",
               checked_count, touch_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
